// ----- rtl/cpuio_pkg.sv -----
`default_nettype none

package cpuio_pkg;

   // operation codes
   localparam logic [2:0] OP_BUS_WRITE  = 3'd0;
   localparam logic [2:0] OP_BUS_READ   = 3'd1;
   localparam logic [2:0] OP_LOAD_PAD   = 3'd2;
   localparam logic [2:0] OP_LOAD_STAT  = 3'd3;
   localparam logic [2:0] OP_RAISE_FLAG = 3'd4;

   // bus write map
   localparam logic [15:0] ADDR_NMITIMEN = 16'h4200;
   localparam logic [15:0] ADDR_WRIO     = 16'h4201;
   localparam logic [15:0] ADDR_WRMPYA   = 16'h4202;
   localparam logic [15:0] ADDR_WRMPYB   = 16'h4203;
   localparam logic [15:0] ADDR_WRDIVL   = 16'h4204;
   localparam logic [15:0] ADDR_WRDIVH   = 16'h4205;
   localparam logic [15:0] ADDR_WRDIVB   = 16'h4206;
   localparam logic [15:0] ADDR_HTIMEL   = 16'h4207;
   localparam logic [15:0] ADDR_HTIMEH   = 16'h4208;
   localparam logic [15:0] ADDR_VTIMEL   = 16'h4209;
   localparam logic [15:0] ADDR_VTIMEH   = 16'h420A;
   localparam logic [15:0] ADDR_MEMSEL   = 16'h420D;

   // bus read map
   localparam logic [15:0] ADDR_RDNMI    = 16'h4210;
   localparam logic [15:0] ADDR_TIMEUP   = 16'h4211;
   localparam logic [15:0] ADDR_HVBJOY   = 16'h4212;
   localparam logic [15:0] ADDR_RDIO     = 16'h4213;
   localparam logic [15:0] ADDR_RDDIVL   = 16'h4214;
   localparam logic [15:0] ADDR_RDDIVH   = 16'h4215;
   localparam logic [15:0] ADDR_RDMPYL   = 16'h4216;
   localparam logic [15:0] ADDR_RDMPYH   = 16'h4217;
   localparam logic [15:0] ADDR_PAD_FIRST = 16'h4218;
   localparam logic [15:0] ADDR_PAD_LAST  = 16'h421F;

   // configuration register indexes
   localparam logic CSR_CPU_VERSION = 1'b0;

   localparam int          PAD_COUNT_DEFAULT = 4;
   localparam int          PAD_SLOTS         = 4;
   localparam logic [3:0]  CPU_VERSION_RESET = 4'h2;
   localparam logic [15:0] DIV_ZERO_QUOTIENT = 16'hFFFF;
   localparam logic [7:0]  TIMER_FLAG_SET    = 8'h80;

   localparam logic [3:0]  MUL_STEPS_M1 = 4'd7;
   localparam logic [3:0]  DIV_STEPS_M1 = 4'd15;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [1:0]  pad_index;
      logic [15:0] pad_value;
      logic [7:0]  blank_status;
      logic [7:0]  port_in;
      logic        raise_nmi;
      logic        raise_timer;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       auto_pad_read;
      logic [7:0] irq_enable_bits;
      logic [7:0] port_out;
      logic [8:0] h_compare;
      logic [8:0] v_compare;
      logic [7:0] fast_rom;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [15:0] scan;     // multiplier in high byte, or dividend
      logic [7:0]  operand;  // multiplicand, or divisor
   } mdu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
      logic [15:0] remainder; // product for a multiply
   } mdu_res_type;

endpackage

`default_nettype wire

// ----- rtl/cpuio_mdu.sv -----
`default_nettype none

module cpuio_mdu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cpuio_pkg::mdu_cmd_type cmd,
   output      cpuio_pkg::mdu_res_type res
);
   import cpuio_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        is_div_ff, is_div_in;
   logic        bypass_ff, bypass_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] shreg_ff, shreg_in;
   logic [7:0]  opnd_ff, opnd_in;

   logic [15:0] add_x;
   logic [15:0] add_y;
   logic        add_cin;
   logic [16:0] add_sum;
   logic [8:0]  rem_shift;

   // one shared adder: shift-add for multiply, trial subtract for divide
   always_comb begin
      rem_shift = {acc_ff[7:0], shreg_ff[15]};
      if (is_div_ff) begin
         add_x   = {7'd0, rem_shift};
         add_y   = ~{8'd0, opnd_ff};
         add_cin = 1'b1;
      end else begin
         add_x   = {acc_ff[14:0], 1'b0};
         add_y   = shreg_ff[15] ? {8'd0, opnd_ff} : 16'd0;
         add_cin = 1'b0;
      end
      add_sum = {1'b0, add_x} + {1'b0, add_y} + {16'd0, add_cin};
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      bypass_in = bypass_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      shreg_in  = shreg_ff;
      opnd_in   = opnd_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         is_div_in = cmd.is_div;
         opnd_in   = cmd.operand;
         cnt_in    = cmd.is_div ? DIV_STEPS_M1 : MUL_STEPS_M1;
         // zero divisor: load the fixed answer and skip the steps
         bypass_in = cmd.is_div && (cmd.operand == 8'd0);
         acc_in    = bypass_in ? cmd.scan : 16'd0;
         shreg_in  = bypass_in ? DIV_ZERO_QUOTIENT : cmd.scan;
      end else if (busy_ff) begin
         if (!bypass_ff) begin
            if (is_div_ff) begin
               acc_in   = add_sum[16] ? add_sum[15:0] : add_x;
               shreg_in = {shreg_ff[14:0], add_sum[16]};
            end else begin
               acc_in   = add_sum[15:0];
               shreg_in = {shreg_ff[14:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 4'd1;
         if (bypass_ff || cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      bypass_ff <= bypass_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      shreg_ff  <= shreg_in;
      opnd_ff   <= opnd_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = shreg_ff;
   assign res.remainder = acc_ff;

`ifndef SYNTH
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start)
      else $error("mdu started while busy");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cmd.start && cnt_ff == 4'd0) |=> (!busy_ff && done_ff))
      else $error("mdu did not finish after last step");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("mdu done while still busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/cpu_io_registers_mul_div_top.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_data  (cpuio_pkg::req_type)
// rsp_      out        rsp_valid/rsp_ready    rsp_data  (cpuio_pkg::rsp_type)
// csr_      in/out     APB psel/penable/...   cpu_version at byte address 0
//
// Plain items answer in the cycle after acceptance. A write to WRMPYB runs 8
// shift-add steps and a write to WRDIVB 16 divide steps on the shared adder
// in cpuio_mdu before their result is registered as the response; a zero
// divisor skips the steps.
// reset is synchronous and loads the power-on register values.
// req_ready is low while the adder runs and while an unread result stalls.

module cpu_io_registers_mul_div_top #(
   parameter int PAD_COUNT = cpuio_pkg::PAD_COUNT_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire cpuio_pkg::req_type req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      cpuio_pkg::rsp_type rsp_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output      logic [31:0]        csr_prdata,
   output      logic               csr_pready
);
   import cpuio_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_BUSY = 1'b1;

   logic        state_ff, state_in;
   logic [3:0]  cpu_version_ff, cpu_version_in;
   logic [7:0]  enable_ff, enable_in;
   logic        auto_pad_ff, auto_pad_in;
   logic [7:0]  port_out_ff, port_out_in;
   logic [7:0]  mul_a_ff, mul_a_in;
   logic [15:0] dividend_ff, dividend_in;
   logic [15:0] quotient_ff, quotient_in;
   logic [15:0] prod_rem_ff, prod_rem_in;
   logic [8:0]  h_time_ff, h_time_in;
   logic [8:0]  v_time_ff, v_time_in;
   logic [7:0]  speed_ff, speed_in;
   logic [7:0]  nmi_status_ff, nmi_status_in;
   logic [7:0]  timer_flag_ff, timer_flag_in;
   logic [7:0]  blank_ff, blank_in;
   logic [7:0]  port_in_ff, port_in_in;
   logic [15:0] pad_ff [PAD_SLOTS];
   logic [15:0] pad_in [PAD_SLOTS];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   // quotient only changes on a divide; remember which kind is in flight
   logic        div_run_ff, div_run_in;

   logic        accept;
   logic        csr_write;
   logic [7:0]  rdata;
   logic [1:0]  pad_sel;
   logic        pad_present;
   mdu_cmd_type mdu_cmd;
   mdu_res_type mdu_res;

   cpuio_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (mdu_cmd),
      .res   (mdu_res)
   );

   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_CPU_VERSION) ? {28'd0, cpu_version_ff} : 32'd0;

   assign pad_sel     = req_data.address[2:1];
   assign pad_present = 32'(pad_sel) < PAD_COUNT;

   always_comb begin
      state_in       = state_ff;
      cpu_version_in = cpu_version_ff;
      enable_in      = enable_ff;
      auto_pad_in    = auto_pad_ff;
      port_out_in    = port_out_ff;
      mul_a_in       = mul_a_ff;
      dividend_in    = dividend_ff;
      quotient_in    = quotient_ff;
      prod_rem_in    = prod_rem_ff;
      h_time_in      = h_time_ff;
      v_time_in      = v_time_ff;
      speed_in       = speed_ff;
      nmi_status_in  = nmi_status_ff;
      timer_flag_in  = timer_flag_ff;
      blank_in       = blank_ff;
      port_in_in     = port_in_ff;
      pad_in         = pad_ff;
      div_run_in     = div_run_ff;
      rdata          = 8'd0;
      mdu_cmd.start   = 1'b0;
      mdu_cmd.is_div  = 1'b0;
      mdu_cmd.scan    = {req_data.write_data, 8'd0};
      mdu_cmd.operand = mul_a_ff;

      if (csr_write && csr_paddr[2] == CSR_CPU_VERSION) begin
         cpu_version_in = csr_pwdata[3:0];
         nmi_status_in  = {nmi_status_ff[7:4], csr_pwdata[3:0]};
      end

      if (accept) begin
         case (req_data.operation)
            OP_BUS_WRITE: begin
               case (req_data.address)
                  ADDR_NMITIMEN: begin
                     enable_in   = req_data.write_data;
                     auto_pad_in = req_data.write_data[0];
                  end
                  ADDR_WRIO:   port_out_in = req_data.write_data;
                  ADDR_WRMPYA: mul_a_in    = req_data.write_data;
                  ADDR_WRMPYB: begin
                     mdu_cmd.start = 1'b1;
                     state_in      = S_BUSY;
                  end
                  ADDR_WRDIVL: dividend_in = {dividend_ff[15:8], req_data.write_data};
                  ADDR_WRDIVH: dividend_in = {req_data.write_data, dividend_ff[7:0]};
                  ADDR_WRDIVB: begin
                     mdu_cmd.start   = 1'b1;
                     mdu_cmd.is_div  = 1'b1;
                     mdu_cmd.scan    = dividend_ff;
                     mdu_cmd.operand = req_data.write_data;
                     state_in        = S_BUSY;
                  end
                  ADDR_HTIMEL: h_time_in = {h_time_ff[8], req_data.write_data};
                  ADDR_HTIMEH: h_time_in = {req_data.write_data[0], h_time_ff[7:0]};
                  ADDR_VTIMEL: v_time_in = {v_time_ff[8], req_data.write_data};
                  ADDR_VTIMEH: v_time_in = {req_data.write_data[0], v_time_ff[7:0]};
                  ADDR_MEMSEL: speed_in  = req_data.write_data;
                  default: ;
               endcase
            end
            OP_BUS_READ: begin
               if (req_data.address inside {[ADDR_PAD_FIRST:ADDR_PAD_LAST]}) begin
                  if (pad_present) begin
                     rdata = req_data.address[0] ? pad_ff[pad_sel][15:8]
                                                 : pad_ff[pad_sel][7:0];
                  end
               end else begin
                  case (req_data.address)
                     ADDR_RDNMI: begin
                        rdata            = nmi_status_ff;
                        nmi_status_in[7] = 1'b0;
                     end
                     ADDR_TIMEUP: begin
                        rdata         = timer_flag_ff;
                        timer_flag_in = 8'd0;
                     end
                     ADDR_HVBJOY: rdata = blank_ff;
                     ADDR_RDIO:   rdata = port_in_ff;
                     ADDR_RDDIVL: rdata = quotient_ff[7:0];
                     ADDR_RDDIVH: rdata = quotient_ff[15:8];
                     ADDR_RDMPYL: rdata = prod_rem_ff[7:0];
                     ADDR_RDMPYH: rdata = prod_rem_ff[15:8];
                     default:     rdata = 8'd0;
                  endcase
               end
            end
            OP_LOAD_PAD: begin
               if (32'(req_data.pad_index) < PAD_COUNT) begin
                  pad_in[req_data.pad_index] = req_data.pad_value;
               end
            end
            OP_LOAD_STAT: begin
               blank_in   = req_data.blank_status;
               port_in_in = req_data.port_in;
            end
            OP_RAISE_FLAG: begin
               if (req_data.raise_nmi) begin
                  nmi_status_in[7] = 1'b1;
               end
               if (req_data.raise_timer) begin
                  timer_flag_in = TIMER_FLAG_SET;
               end
            end
            default: ;
         endcase
      end

      if (mdu_cmd.start) begin
         div_run_in = mdu_cmd.is_div;
      end

      // take the finished product or quotient/remainder
      if (mdu_res.done) begin
         state_in    = S_IDLE;
         prod_rem_in = mdu_res.remainder;
         if (div_run_ff) begin
            quotient_in = mdu_res.quotient;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((accept && !mdu_cmd.start) || mdu_res.done) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.read_data       = rdata;
         rsp_data_in.auto_pad_read   = auto_pad_in;
         rsp_data_in.irq_enable_bits = enable_in;
         rsp_data_in.port_out        = port_out_in;
         rsp_data_in.h_compare       = h_time_in;
         rsp_data_in.v_compare       = v_time_in;
         rsp_data_in.fast_rom        = speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cpu_version_ff <= CPU_VERSION_RESET;
         enable_ff      <= 8'd0;
         auto_pad_ff    <= 1'b0;
         port_out_ff    <= 8'd0;
         mul_a_ff       <= 8'd0;
         dividend_ff    <= 16'd0;
         quotient_ff    <= 16'd0;
         prod_rem_ff    <= 16'd0;
         h_time_ff      <= 9'd0;
         v_time_ff      <= 9'd0;
         speed_ff       <= 8'd0;
         nmi_status_ff  <= {4'd0, CPU_VERSION_RESET};
         timer_flag_ff  <= 8'd0;
         blank_ff       <= 8'd0;
         port_in_ff     <= 8'd0;
         for (int i = 0; i < PAD_SLOTS; i++) begin
            pad_ff[i] <= 16'd0;
         end
         rsp_valid_ff   <= 1'b0;
         div_run_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cpu_version_ff <= cpu_version_in;
         enable_ff      <= enable_in;
         auto_pad_ff    <= auto_pad_in;
         port_out_ff    <= port_out_in;
         mul_a_ff       <= mul_a_in;
         dividend_ff    <= dividend_in;
         quotient_ff    <= quotient_in;
         prod_rem_ff    <= prod_rem_in;
         h_time_ff      <= h_time_in;
         v_time_ff      <= v_time_in;
         speed_ff       <= speed_in;
         nmi_status_ff  <= nmi_status_in;
         timer_flag_ff  <= timer_flag_in;
         blank_ff       <= blank_in;
         port_in_ff     <= port_in_in;
         pad_ff         <= pad_in;
         rsp_valid_ff   <= rsp_valid_in;
         div_run_ff     <= div_run_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> !req_ready)
      else $error("item accepted while the mul/div unit runs");
   a_done_only_busy: assert property (@(posedge clock) disable iff (reset)
      mdu_res.done |-> (state_ff == S_BUSY))
      else $error("mul/div result with no item in flight");
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      mdu_res.done |=> rsp_valid_ff)
      else $error("mul/div result not presented");
   a_version_mirror: assert property (@(posedge clock) disable iff (reset)
      nmi_status_ff[3:0] == cpu_version_ff)
      else $error("RDNMI version bits out of step with cpu_version");
`endif

endmodule

`default_nettype wire
